### hw/rtl/ppcg_pkg.sv
package ppcg_pkg;

  // colour table geometry
  localparam int COLOUR_ENTRIES = 16;
  localparam int IDX_W          = $clog2(COLOUR_ENTRIES);
  localparam int PIX_SLOTS      = 16;
  localparam int POS_W          = $clog2(PIX_SLOTS);
  localparam int PTR_W          = 5;
  localparam int ROWS           = 16;
  localparam int ROW_W          = $clog2(ROWS);

  // item modes
  localparam logic [2:0] MODE_RENDER    = 3'd0;
  localparam logic [2:0] MODE_SET_PTR   = 3'd1;
  localparam logic [2:0] MODE_WRITE     = 3'd2;
  localparam logic [2:0] MODE_READ_BYTE = 3'd3;
  localparam logic [2:0] MODE_READ_PTR  = 3'd4;

  // pixel formats
  localparam logic [2:0] FMT_PAGE1     = 3'd0;
  localparam logic [2:0] FMT_PAGE2     = 3'd1;
  localparam logic [2:0] FMT_40COL     = 3'd2;
  localparam logic [2:0] FMT_80COL     = 3'd3;
  localparam logic [2:0] FMT_2BPP      = 3'd4;
  localparam logic [2:0] FMT_4BPP      = 3'd5;
  localparam logic [2:0] FMT_OVER      = 3'd6;
  localparam logic [2:0] FMT_TRIPLE    = 3'd7;

  // column width codes
  localparam logic [1:0] WSEL_4 = 2'd0;
  localparam logic [1:0] WSEL_8 = 2'd1;

  // register indexes
  localparam logic CFG_PIXEL_FORMAT = 1'b0;
  localparam logic CFG_COLUMN_WIDTH = 1'b1;

  localparam logic [2:0] FMT_RESET  = FMT_40COL;
  localparam logic [1:0] WSEL_RESET = WSEL_8;

  typedef logic [IDX_W-1:0] cidx_t;
  typedef cidx_t [PIX_SLOTS-1:0] cidx_row_t;
  typedef logic [11:0] colour_t;

  localparam colour_t DEFAULT_COLOURS [COLOUR_ENTRIES] = '{
    12'h000, 12'hf55, 12'h0f0, 12'hff0, 12'h55f, 12'hf0f, 12'h5ff, 12'hfff,
    12'haaa, 12'hfaa, 12'hafa, 12'hffa, 12'h5af, 12'hfaf, 12'haff, 12'hfa5
  };

  // one column or read result handed to the serializer
  typedef struct packed {
    cidx_row_t        idx;
    logic [POS_W-1:0] last_pos;
    logic             is_read;
    logic [7:0]       rd;
  } ser_load_t;

  // register item side effects on the palette store
  typedef struct packed {
    logic       set_ptr;
    logic       write;
    logic       advance;
    logic [7:0] data;
  } pal_cmd_t;

endpackage

### hw/rtl/palette_pixel_column_generator_unit.sv
// channel | direction | handshake            | payload
// in      | sink      | in_tvalid/in_tready   | tuser mode, tdata column bytes, write_data
// out     | source    | out_tvalid/out_tready | tdata colour, read_data; tlast
// cfg     | sink      | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// a render item gives 4, 8 or 16 results, one per cycle unless out_tready stalls,
// set by the slot counter of the serializer and the single colour table read port;
// read items give one result, pointer set and byte write items give none.
// an item passes the input register, the serializer and the output register in turn.
// rst_n is synchronous; it restores the default colour table and zero palette bytes.
// out_tready low stalls the serializer and, once it is full, the input register.
module palette_pixel_column_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_byte, attribute_byte, write_data
  input  logic [2:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_colour, read_data, zero pad
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);
  import ppcg_pkg::*;

  logic [2:0] fmt_r;
  logic [1:0] wsel_r;

  logic       in_v_r;
  logic [2:0] mode_r;
  logic [7:0] b0_r;
  logic [7:0] b1_r;
  logic [7:0] wd_r;

  logic             ser_free;
  logic             consume;
  ser_load_t        load;
  logic             load_valid;
  pal_cmd_t         cmd;
  cidx_t            colour_idx;
  colour_t          colour;
  logic [PTR_W-1:0] pointer;
  logic [7:0]       pointer_byte;
  cidx_row_t        idx;
  logic [POS_W-1:0] last_pos;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_RESET;
      wsel_r <= WSEL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PIXEL_FORMAT) fmt_r <= cfg_data;
      else wsel_r <= cfg_data[1:0];
    end
  end

  // input register
  assign consume   = in_v_r && ser_free;
  assign in_tready = !in_v_r || ser_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r <= in_tuser;
      b0_r   <= in_tdata[7:0];
      b1_r   <= in_tdata[15:8];
      wd_r   <= in_tdata[23:16];
    end
  end

  ppcg_column_decode u_decode (
    .pixel_format        (fmt_r),
    .column_width_select (wsel_r),
    .pixel_byte          (b0_r),
    .attribute_byte      (b1_r),
    .idx                 (idx),
    .last_pos            (last_pos)
  );

  // register item side effects, taken when the item leaves the input register
  always_comb begin
    cmd.set_ptr = consume && (mode_r == MODE_SET_PTR);
    cmd.write   = consume && (mode_r == MODE_WRITE);
    cmd.advance = consume && (mode_r == MODE_READ_BYTE);
    cmd.data    = wd_r;
  end

  ppcg_palette u_palette (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .colour_idx   (colour_idx),
    .colour       (colour),
    .pointer      (pointer),
    .pointer_byte (pointer_byte)
  );

  // serializer load for render and read items
  always_comb begin
    load.idx      = idx;
    load.last_pos = last_pos;
    load.is_read  = mode_r != MODE_RENDER;
    load.rd       = (mode_r == MODE_READ_BYTE) ? pointer_byte : 8'(pointer);
    if (mode_r != MODE_RENDER) load.last_pos = '0;
    load_valid = consume && (mode_r == MODE_RENDER || mode_r == MODE_READ_BYTE ||
                             mode_r == MODE_READ_PTR);
  end

  ppcg_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load       (load),
    .ser_free   (ser_free),
    .colour_idx (colour_idx),
    .colour     (colour),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // a read result carries no colour and closes its item
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19:12] != 8'd0 |-> out_tdata[11:0] == 12'd0 && out_tlast)
    else $error("read result with colour or without last");

  // a held input item is not dropped while the serializer is busy
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !ser_free |=> in_v_r)
    else $error("input item lost while serializer busy");

  // a stalled result keeps its data
  a_free_on_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !ser_free |=> $stable(out_tdata))
    else $error("output register changed while stalled");

endmodule

### hw/rtl/ppcg_column_decode.sv
module ppcg_column_decode (
  input  logic [2:0]                        pixel_format,
  input  logic [1:0]                        column_width_select,
  input  logic [7:0]                        pixel_byte,
  input  logic [7:0]                        attribute_byte,
  output ppcg_pkg::cidx_row_t               idx,
  output logic [ppcg_pkg::POS_W-1:0]        last_pos
);
  import ppcg_pkg::*;

  function automatic cidx_t triple_map(input logic [3:0] code);
    cidx_t r;
    if (!code[3]) r = cidx_t'(0);
    else if (code[3:2] == 2'b11) r = cidx_t'(12);
    else if (code == 4'd11) r = cidx_t'(10);
    else r = cidx_t'(code);
    return r;
  endfunction

  logic [7:0] bits;
  cidx_t      c0;
  cidx_t      c1;

  // two-colour source for the page and 40-column formats
  always_comb begin
    bits = pixel_byte;
    c0   = cidx_t'(8);
    c1   = cidx_t'(9);
    if (pixel_format == FMT_PAGE2) begin
      bits = attribute_byte;
      c1   = cidx_t'(10);
    end else if (pixel_format == FMT_40COL) begin
      c0 = cidx_t'(attribute_byte[3:0]);
      c1 = cidx_t'(attribute_byte[7:4]);
    end
  end

  // per-slot colour indexes
  always_comb begin
    idx = '0;
    unique case (pixel_format)
      FMT_PAGE1, FMT_PAGE2, FMT_40COL: begin
        for (int i = 0; i < 8; i++) idx[i] = bits[7-i] ? c1 : c0;
        for (int i = 8; i < PIX_SLOTS; i++) idx[i] = c0;
      end
      FMT_80COL: begin
        for (int i = 0; i < 8; i++) begin
          idx[2*i]   = cidx_t'(pixel_byte[7-i]);
          idx[2*i+1] = cidx_t'(attribute_byte[7-i]);
        end
      end
      FMT_2BPP: begin
        for (int i = 0; i < 4; i++) begin
          idx[i]   = cidx_t'(pixel_byte[6-2*i +: 2]);
          idx[4+i] = cidx_t'(attribute_byte[6-2*i +: 2]);
        end
      end
      FMT_4BPP: begin
        idx[0] = cidx_t'(pixel_byte[7:4]);
        idx[1] = cidx_t'(pixel_byte[3:0]);
        idx[2] = cidx_t'(attribute_byte[7:4]);
        idx[3] = cidx_t'(attribute_byte[3:0]);
      end
      FMT_TRIPLE: begin
        idx[0] = triple_map(pixel_byte[7:4]);
        idx[1] = triple_map(pixel_byte[3:0]);
        idx[2] = triple_map(attribute_byte[7:4]);
        idx[3] = triple_map(attribute_byte[3:0]);
      end
      FMT_OVER: begin
        // bank 0 wins over bank 1, neither gives the background
        for (int i = 0; i < 8; i++) begin
          idx[i] = pixel_byte[7-i] ? cidx_t'(9) :
                   (attribute_byte[7-i] ? cidx_t'(10) : cidx_t'(8));
        end
        for (int i = 8; i < PIX_SLOTS; i++) idx[i] = cidx_t'(8);
      end
      default: idx = '0;
    endcase
  end

  // last slot from the width code, the unused codes acting as 16 pixels
  always_comb begin
    unique case (column_width_select)
      WSEL_4:  last_pos = POS_W'(3);
      WSEL_8:  last_pos = POS_W'(7);
      default: last_pos = POS_W'(PIX_SLOTS - 1);
    endcase
  end

endmodule

### hw/rtl/ppcg_palette.sv
module ppcg_palette (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppcg_pkg::pal_cmd_t            cmd,
  input  ppcg_pkg::cidx_t               colour_idx,
  output ppcg_pkg::colour_t             colour,
  output logic [ppcg_pkg::PTR_W-1:0]    pointer,
  output logic [7:0]                    pointer_byte
);
  import ppcg_pkg::*;

  logic [PTR_W-1:0] ptr_r;
  logic [PTR_W-1:0] ptr_nxt;
  logic [15:0]      bytes_r [ROWS];
  colour_t          table_r [COLOUR_ENTRIES];

  logic [ROW_W-1:0] row;
  logic [15:0]      pair;
  logic [15:0]      pair_nxt;

  // each row holds the even byte low and the odd byte high
  assign row          = ptr_r[PTR_W-1:1];
  assign pair         = bytes_r[row];
  assign pointer_byte = ptr_r[0] ? pair[15:8] : pair[7:0];
  assign pointer      = ptr_r;
  assign colour       = table_r[colour_idx];

  always_comb begin
    pair_nxt = pair;
    if (ptr_r[0]) pair_nxt[15:8] = cmd.data;
    else pair_nxt[7:0] = cmd.data;
  end

  // pointer update
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.set_ptr) ptr_nxt = cmd.data[PTR_W-1:0];
    else if (cmd.write || cmd.advance) ptr_nxt = ptr_r + PTR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  // palette bytes and colour table, rebuilt one entry per byte write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) bytes_r[i] <= '0;
      for (int i = 0; i < COLOUR_ENTRIES; i++) table_r[i] <= DEFAULT_COLOURS[i];
    end else if (cmd.write) begin
      bytes_r[row] <= pair_nxt;
      table_r[row] <= {pair_nxt[3:0], pair_nxt[7:4], pair_nxt[11:8]};
    end
  end

endmodule

### hw/rtl/ppcg_serializer.sv
module ppcg_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_valid,
  input  ppcg_pkg::ser_load_t   load,
  output logic                  ser_free,
  output ppcg_pkg::cidx_t       colour_idx,
  input  ppcg_pkg::colour_t     colour,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,
  output logic                  out_tlast
);
  import ppcg_pkg::*;

  logic             ser_v_r;
  ser_load_t        cur_r;
  logic [POS_W-1:0] pos_r;
  logic             adv;
  logic             at_last;

  logic             out_v_r;
  colour_t          out_colour_r;
  logic [7:0]       out_rd_r;
  logic             out_last_r;

  assign adv        = ser_v_r && (!out_v_r || out_tready);
  assign at_last    = pos_r == cur_r.last_pos;
  assign ser_free   = !ser_v_r || (adv && at_last);
  assign colour_idx = cur_r.idx[pos_r];

  // column hold and slot counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      pos_r   <= '0;
    end else if (ser_free) begin
      ser_v_r <= load_valid;
      pos_r   <= '0;
    end else if (adv) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free && load_valid) cur_r <= load;
  end

  // output register, one transfer per slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_colour_r <= cur_r.is_read ? '0 : colour;
      out_rd_r     <= cur_r.is_read ? cur_r.rd : 8'd0;
      out_last_r   <= at_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_rd_r, out_colour_r};
  assign out_tlast  = out_last_r;

endmodule

### tb/ppcg_pixel_monitor.sv
`timescale 1ns / 1ps
module ppcg_pixel_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_byte, attribute_byte, write_data
  input  logic [2:0]  in_tuser,   // mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // pixel_colour, read_data, zero pad
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  output int          mismatches,
  output int          pending
);
  import ppcg_pkg::*;

  typedef struct packed {
    colour_t    colour;
    logic [7:0] rd;
    logic       last;
  } pixel_result_t;

  // shadow copy of the block state
  colour_t          colour_tab [COLOUR_ENTRIES];
  logic [7:0]       pal_bytes [32];
  logic [PTR_W-1:0] pal_ptr;
  logic [2:0]       fmt;
  logic [1:0]       wsel;
  pixel_result_t    pixel_queue [$];

  // triple overprint code to table entry
  function automatic cidx_t triple_entry(input logic [3:0] code);
    if (code < 4'd8) return '0;
    if (code == 4'd11) return 4'd10;
    if (code >= 4'd12) return 4'd12;
    return code;
  endfunction

  // expected pixels of one column under the current format and width
  task automatic expand_column(input logic [7:0] b0, input logic [7:0] b1);
    colour_t    px [PIX_SLOTS];
    colour_t    c0, c1;
    logic [7:0] bits, under;
    logic [3:0] codes [4];
    int         count;
    case (fmt)
      FMT_PAGE1, FMT_PAGE2, FMT_40COL: begin
        bits = (fmt == FMT_PAGE2) ? b1 : b0;
        if (fmt == FMT_PAGE1) begin
          c0 = colour_tab[8];
          c1 = colour_tab[9];
        end else if (fmt == FMT_PAGE2) begin
          c0 = colour_tab[8];
          c1 = colour_tab[10];
        end else begin
          c0 = colour_tab[b1[3:0]];
          c1 = colour_tab[b1[7:4]];
        end
        for (int i = 0; i < 8; i++) px[i] = bits[7-i] ? c1 : c0;
        for (int i = 8; i < PIX_SLOTS; i++) px[i] = c0;
      end
      FMT_80COL: begin
        // banks interleave, high bit first
        for (int i = 0; i < 8; i++) begin
          px[2*i]   = colour_tab[{3'b000, b0[7-i]}];
          px[2*i+1] = colour_tab[{3'b000, b1[7-i]}];
        end
      end
      FMT_2BPP: begin
        for (int i = 0; i < 4; i++) begin
          px[i]   = colour_tab[{2'b00, b0[7-2*i -: 2]}];
          px[4+i] = colour_tab[{2'b00, b1[7-2*i -: 2]}];
        end
        for (int i = 8; i < PIX_SLOTS; i++) px[i] = colour_tab[0];
      end
      FMT_4BPP, FMT_TRIPLE: begin
        codes[0] = b0[7:4];
        codes[1] = b0[3:0];
        codes[2] = b1[7:4];
        codes[3] = b1[3:0];
        for (int i = 0; i < 4; i++)
          px[i] = colour_tab[(fmt == FMT_TRIPLE) ? triple_entry(codes[i]) : codes[i]];
        for (int i = 4; i < PIX_SLOTS; i++) px[i] = colour_tab[0];
      end
      default: begin
        // overprint: bank 0 lies over bank 1
        under = b1 & ~b0;
        for (int i = 0; i < 8; i++)
          px[i] = b0[7-i] ? colour_tab[9] : (under[7-i] ? colour_tab[10] : colour_tab[8]);
        for (int i = 8; i < PIX_SLOTS; i++) px[i] = colour_tab[8];
      end
    endcase
    count = (wsel == WSEL_4) ? 4 : ((wsel == WSEL_8) ? 8 : 16);
    for (int i = 0; i < count; i++)
      pixel_queue.push_back(pixel_result_t'{px[i], 8'h00, (i == count - 1)});
  endtask

  // byte write at the pointer rebuilds one colour entry
  task automatic store_palette_byte(input logic [7:0] wd);
    logic [PTR_W-1:0] idx;
    logic [7:0]       rg, bl;
    idx = pal_ptr;
    pal_ptr = pal_ptr + 1'b1;
    pal_bytes[idx] = wd;
    rg = pal_bytes[{idx[PTR_W-1:1], 1'b0}];
    bl = pal_bytes[{idx[PTR_W-1:1], 1'b1}];
    colour_tab[idx[PTR_W-1:1]] = {rg[3:0], rg[7:4], bl[3:0]};
  endtask

  function automatic void note(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatches++;
  endfunction

  always @(posedge clk) begin : watch
    pixel_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < COLOUR_ENTRIES; i++) colour_tab[i] = DEFAULT_COLOURS[i];
      for (int i = 0; i < 32; i++) pal_bytes[i] = 8'h00;
      pal_ptr    = '0;
      fmt        = FMT_RESET;
      wsel       = WSEL_RESET;
      mismatches = 0;
      pixel_queue.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_tvalid && out_tready) begin
        got = pixel_result_t'{out_tdata[11:0], out_tdata[19:12], out_tlast};
        if (pixel_queue.size() == 0) begin
          note("unexpected result", 0, got);
        end else begin
          want = pixel_queue.pop_front();
          if (got.colour !== want.colour) note("pixel_colour", want.colour, got.colour);
          if (got.rd !== want.rd) note("read_data", want.rd, got.rd);
          if (got.last !== want.last) note("last", want.last, got.last);
        end
      end

      // register write transfer
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PIXEL_FORMAT) fmt = cfg_data;
        else wsel = cfg_data[1:0];
      end

      // input transfer
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          MODE_RENDER:    expand_column(in_tdata[7:0], in_tdata[15:8]);
          MODE_SET_PTR:   pal_ptr = in_tdata[16 +: PTR_W];
          MODE_WRITE:     store_palette_byte(in_tdata[23:16]);
          MODE_READ_BYTE: begin
            pixel_queue.push_back(pixel_result_t'{12'h000, pal_bytes[pal_ptr], 1'b1});
            pal_ptr = pal_ptr + 1'b1;
          end
          MODE_READ_PTR:
            pixel_queue.push_back(pixel_result_t'{12'h000, {3'b000, pal_ptr}, 1'b1});
          default: ;
        endcase
      end
    end
    pending = pixel_queue.size();
  end

endmodule

### tb/palette_pixel_column_generator_unit_tb.sv
`timescale 1ns / 1ps
module palette_pixel_column_generator_unit_tb;
  import ppcg_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 360;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // pixel_byte, attribute_byte, write_data
  logic [2:0]  in_tuser   = MODE_RENDER;  // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // pixel_colour, read_data, zero pad
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = CFG_PIXEL_FORMAT;
  logic [2:0]  cfg_data   = '0;

  int mismatches;
  int pending;
  bit full_rate   = 1'b0;
  int idle_cycles = 0;
  int ready_run   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  palette_pixel_column_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ppcg_pixel_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // receiver stalls: mostly short, a few long, none in full rate phases
  always @(negedge clk) begin : ready_gen
    int r;
    if (full_rate) begin
      out_tready <= 1'b1;
    end else if (ready_run > 0) begin
      ready_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_tready <= 1'b1;
        ready_run = $urandom_range(0, 12);
      end else if (r < 90) begin
        out_tready <= 1'b0;
        ready_run = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_run = $urandom_range(10, 30);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("palette_pixel_column_generator_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transfer after a random gap
  task automatic push_item(input logic [2:0] mode, input logic [7:0] pix,
                           input logic [7:0] attr, input logic [7:0] wdat);
    int r, gap;
    r = $urandom_range(0, 99);
    if (full_rate || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {wdat, attr, pix};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [2:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain all results, then let register-only items finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_item(output bit counted);
    int         r;
    logic [2:0] mode;
    r = $urandom_range(0, 99);
    if (r < 58) mode = MODE_RENDER;
    else if (r < 70) mode = MODE_WRITE;
    else if (r < 78) mode = MODE_SET_PTR;
    else if (r < 88) mode = MODE_READ_BYTE;
    else if (r < 95) mode = MODE_READ_PTR;
    else mode = MODE_READ_PTR + 3'($urandom_range(1, 3));
    counted = (mode <= MODE_READ_PTR);
    push_item(mode, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin : stimulus
    int done_items;
    int phase;
    bit counted;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration, pointer wrap, byte write and reads
    push_item(MODE_RENDER, 8'hA5, 8'h3C, 8'h00);
    push_item(MODE_READ_PTR, 8'h00, 8'h00, 8'h00);
    push_item(MODE_READ_BYTE, 8'h00, 8'h00, 8'h00);
    push_item(MODE_SET_PTR, 8'h00, 8'h00, 8'hFF);
    push_item(MODE_READ_PTR, 8'h00, 8'h00, 8'h00);
    push_item(MODE_WRITE, 8'h00, 8'h00, 8'h5A);
    push_item(MODE_SET_PTR, 8'h00, 8'h00, 8'h1E);
    push_item(MODE_WRITE, 8'h00, 8'h00, 8'hC3);
    push_item(MODE_READ_BYTE, 8'h00, 8'h00, 8'h00);
    push_item(MODE_READ_PTR + 3'd1, 8'hFF, 8'hFF, 8'hFF);
    push_item(MODE_READ_PTR + 3'd3, 8'hFF, 8'hFF, 8'hFF);
    push_item(MODE_RENDER, 8'hFF, 8'hF0, 8'h00);

    // every format at sixteen slots, both width codes that give sixteen
    for (int f = 0; f < 8; f++) begin
      settle();
      cfg_write(CFG_PIXEL_FORMAT, 3'(f));
      cfg_write(CFG_COLUMN_WIDTH, {f[1], 1'b1, f[0]});
      push_item(MODE_RENDER, 8'hFF, 8'h00, 8'h00);
      push_item(MODE_RENDER, 8'h8B, 8'h9C, 8'hFF);
    end

    // random phases, each with its own configuration
    done_items = 0;
    phase = 0;
    while (done_items < RANDOM_ITEMS) begin
      settle();
      full_rate = (phase % 3 == 2);
      cfg_write(CFG_PIXEL_FORMAT, 3'($urandom_range(0, 7)));
      cfg_write(CFG_COLUMN_WIDTH, {1'($urandom_range(0, 1)), 2'(phase % 4)});
      repeat (30) begin
        random_item(counted);
        if (counted) done_items++;
      end
      phase++;
    end
    full_rate = 1'b0;
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("palette_pixel_column_generator_unit_tb: PASS");
    end else begin
      $display("palette_pixel_column_generator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### palette_pixel_column_generator_unit.f
hw/rtl/ppcg_pkg.sv
hw/rtl/ppcg_column_decode.sv
hw/rtl/ppcg_palette.sv
hw/rtl/ppcg_serializer.sv
hw/rtl/palette_pixel_column_generator_unit.sv
tb/ppcg_pixel_monitor.sv
tb/palette_pixel_column_generator_unit_tb.sv
